### hw/rtl/next_fit_heap_allocator_defines.svh
// assertion macros shared by the allocator rtl
`ifndef NEXT_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define NEXT_FIT_HEAP_ALLOCATOR_DEFINES_SVH

`ifndef ASSERT_OFF

`define NFH_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

`define NFH_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`define NFH_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define NFH_ASSERT(lbl, clk, rstn, prop, msg)
`define NFH_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define NFH_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

### hw/rtl/nfh_pkg.sv
// types, constants and helpers of the next-fit heap allocator
package nfh_pkg;

	localparam int HEAP_UNITS = 1024;
	localparam int UNIT_BYTES = 8;
	localparam int UB_SHIFT   = $clog2(UNIT_BYTES);
	localparam int ADDR_W     = $clog2(HEAP_UNITS);
	localparam int CNT_W      = 11;
	localparam int NEXT_W     = 11;
	localparam int SIZE_W     = 12;
	localparam int NODE_W     = 12;
	localparam int STEP_W     = 12;
	localparam int BYTES_W    = 16;
	localparam int INDEX_W    = 10;
	localparam int FREE_W     = 10;
	localparam int NUNITS_W   = 14;
	localparam int MIN_HEAP   = 2;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// register index, decoded from paddr[2]
	localparam logic REG_HEAP_UNITS = 1'b0;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_SIZE  = 3'd1,
		ST_NO_FIT    = 3'd2,
		ST_BAD_FREE  = 3'd3,
		ST_NULL_FREE = 3'd4
	} status_t;

	typedef logic [NODE_W-1:0] node_t;

	typedef struct packed {
		logic [NEXT_W-1:0] next;
		logic [SIZE_W-1:0] size;
	} hdr_t;

	localparam int HDR_W = $bits(hdr_t);

	typedef struct packed {
		logic             wr;
		logic [CNT_W-1:0] units;
	} cfg_t;

	typedef struct packed {
		logic               op;
		logic [BYTES_W-1:0] bytes;
		logic [INDEX_W-1:0] index;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [INDEX_W-1:0] blk;
		logic [CNT_W-1:0]   alloc;
		logic [FREE_W-1:0]  free_u;
		logic [CNT_W-1:0]   peak;
	} res_t;

	function automatic logic node_ok(node_t id, logic [CNT_W-1:0] heap);
		return (id != '0) && (id <= NODE_W'(heap));
	endfunction

endpackage

### hw/rtl/next_fit_heap_allocator.sv
// top level: stream ports, apb register, result register around the sequencer
//
// channel   dir   handshake                  payload
// s_*       in    s_tvalid / s_tready        tuser op, tdata request_bytes, data_index
// m_*       out   m_tvalid / m_tready        tuser status, tdata result counters
// apb       in    psel, penable, pready      heap_units at address 0
//
// each request walks the headers on the free list (one ram read and one compare per
// node visited), then sets up and relinks, and it waits in S_DONE while the result
// register is held by the receiver.
// after reset and after every heap_units write the whole header ram is swept,
// during which no request is taken; register writes are still accepted.
// a result waits in its output register while the next request is taken.
`include "next_fit_heap_allocator_defines.svh"

module next_fit_heap_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // request_bytes[15:0], data_index[25:16], zero
	input  logic [0:0]  s_tuser,   // op[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // block_index[9:0], allocated_units[20:10],
	                               // free_units[30:21], peak_units[41:31], zero
	output logic [2:0]  m_tuser,   // status[2:0]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import nfh_pkg::*;

	logic [CNT_W-1:0] heap_units_q;
	logic [CNT_W-1:0] wr_units;
	logic             apb_wr;
	cfg_t             cfg;
	req_t             req;
	res_t             res;
	logic             res_valid, res_ready;
	logic             m_tvalid_q;
	res_t             out_q;

	assign pready   = 1'b1;
	assign apb_wr   = psel && penable && pwrite && (paddr[2] == REG_HEAP_UNITS);
	assign wr_units = pwdata[CNT_W-1:0];
	assign prdata   = (paddr[2] == REG_HEAP_UNITS) ? 32'(heap_units_q) : '0;

	assign cfg.wr    = apb_wr;
	assign cfg.units = heap_units_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_units_q <= CNT_W'(HEAP_UNITS);
		end else if (apb_wr) begin
			if (wr_units < CNT_W'(MIN_HEAP)) begin
				heap_units_q <= CNT_W'(MIN_HEAP);
			end else if (wr_units > CNT_W'(HEAP_UNITS)) begin
				heap_units_q <= CNT_W'(HEAP_UNITS);
			end else begin
				heap_units_q <= wr_units;
			end
		end
	end

	assign req.op    = s_tuser[0];
	assign req.bytes = s_tdata[BYTES_W-1:0];
	assign req.index = s_tdata[BYTES_W+INDEX_W-1:BYTES_W];

	nfh_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.req       (req),
		.req_valid (s_tvalid),
		.req_ready (s_tready),
		.res       (res),
		.res_valid (res_valid),
		.res_ready (res_ready)
	);

	// output beat register
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_q.status;
	assign m_tdata  = {6'b0, out_q.peak, out_q.free_u, out_q.alloc, out_q.blk};

	`NFH_ASSERT_NXT(a_one_at_a_time, clk, arst_n, s_tvalid && s_tready, !s_tready, "request taken while busy")

endmodule

### hw/rtl/nfh_ram.sv
// generic single write, single read ram with registered read data
module nfh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hw/rtl/nfh_core.sv
// free-list sequencer: walks and relinks headers held in the header ram
`include "next_fit_heap_allocator_defines.svh"

module nfh_core (
	input  logic          clk,
	input  logic          arst_n,
	input  nfh_pkg::cfg_t cfg,
	input  nfh_pkg::req_t req,
	input  logic          req_valid,
	output logic          req_ready,
	output nfh_pkg::res_t res,
	output logic          res_valid,
	input  logic          res_ready
);
	import nfh_pkg::*;

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_RD, S_A_CHK, S_A_ROVER, S_A_P, S_A_TAIL,
		S_F_CHK, S_F_BP, S_F_WALK, S_F_UP, S_F_WBP, S_F_WP, S_DONE
	} state_t;

	state_t state_q, ret_q;

	logic [ADDR_W-1:0] clr_q;
	logic              we_q, wclr_q;
	logic [ADDR_W-1:0] waddr_q;
	hdr_t              wdata_q;
	hdr_t              rdata;

	logic [NEXT_W-1:0] sentinel_q;
	node_t             rover_q;
	logic [CNT_W-1:0]  alloc_q, peak_q;

	logic [BYTES_W-1:0] bytes_q;
	node_t              bp_q, p_q, prev_q, rnode_q;
	logic [SIZE_W-1:0]  prev_size_q, p_size_q, bp_size_q;
	logic [NEXT_W-1:0]  bp_next_q;
	logic [STEP_W-1:0]  steps_q;
	status_t            status_q;
	logic [INDEX_W-1:0] blk_q;

	logic [CNT_W-1:0]    heap;
	hdr_t                nd;
	node_t               nd_next;
	logic [BYTES_W:0]    rnd;
	logic [NUNITS_W-1:0] nunits;
	logic                steps_over;
	logic [NUNITS_W:0]   alloc_add;
	logic [CNT_W-1:0]    alloc_sat;
	logic [CNT_W:0]      free_calc;
	logic [SIZE_W-1:0]   tail_size;
	node_t               p2;

	assign heap = cfg.units;

	nfh_ram #(.WIDTH(HDR_W), .DEPTH(HEAP_UNITS)) u_hdr_ram (
		.clk   (clk),
		.we    (we_q),
		.waddr (waddr_q),
		.wdata (wdata_q),
		.raddr (ADDR_W'(rnode_q - node_t'(1))),
		.rdata (rdata)
	);

	// the sentinel lives outside the ram, nodes outside the heap read as zero
	always_comb begin
		if (rnode_q == '0) begin
			nd = '{next: sentinel_q, size: '0};
		end else if (node_ok(rnode_q, heap)) begin
			nd = rdata;
		end else begin
			nd = '0;
		end
	end

	assign nd_next    = NODE_W'(nd.next);
	assign rnd        = {1'b0, bytes_q} + (BYTES_W+1)'(UNIT_BYTES - 1);
	assign nunits     = NUNITS_W'(rnd >> UB_SHIFT) + NUNITS_W'(1);
	assign steps_over = steps_q > (STEP_W'(heap) + STEP_W'(2));
	assign alloc_add  = (NUNITS_W+1)'(alloc_q) + (NUNITS_W+1)'(nunits);
	assign alloc_sat  = (alloc_add > (NUNITS_W+1)'({CNT_W{1'b1}})) ? {CNT_W{1'b1}}
		: alloc_add[CNT_W-1:0];
	assign free_calc  = (CNT_W+1)'(heap) - (CNT_W+1)'(alloc_q) - (CNT_W+1)'(1);
	assign tail_size  = nd.size - SIZE_W'(nunits);
	assign p2         = p_q + NODE_W'(tail_size);

	assign req_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);

	always_comb begin
		res.status = status_q;
		res.blk    = blk_q;
		res.alloc  = alloc_q;
		res.free_u = ((CNT_W+1)'(heap) > (CNT_W+1)'(alloc_q) + (CNT_W+1)'(1))
			? FREE_W'(free_calc) : '0;
		res.peak   = peak_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLR;
			ret_q      <= S_IDLE;
			clr_q      <= '0;
			we_q       <= 1'b0;
			wclr_q     <= 1'b0;
			sentinel_q <= NEXT_W'(1);
			rover_q    <= '0;
			alloc_q    <= '0;
			peak_q     <= '0;
		end else begin
			we_q   <= 1'b0;
			wclr_q <= 1'b0;
			if (cfg.wr) begin
				state_q    <= S_CLR;
				clr_q      <= '0;
				sentinel_q <= NEXT_W'(1);
				rover_q    <= '0;
				alloc_q    <= '0;
			end else begin
				unique case (state_q)
					S_CLR: begin
						// sweep the whole ram, unit zero becomes the single free block
						we_q    <= 1'b1;
						wclr_q  <= 1'b1;
						waddr_q <= clr_q;
						wdata_q <= (clr_q == '0) ? hdr_t'{next: '0, size: SIZE_W'(heap)} : '0;
						clr_q   <= clr_q + ADDR_W'(1);
						if (clr_q == ADDR_W'(HEAP_UNITS - 1)) begin
							state_q <= S_IDLE;
						end
					end
					S_IDLE: begin
						if (req_valid) begin
							bytes_q <= req.bytes;
							bp_q    <= NODE_W'(req.index);
							blk_q   <= '0;
							state_q <= (req.op == OP_FREE) ? S_F_CHK : S_A_CHK;
						end
					end
					S_RD: begin
						state_q <= ret_q;
					end
					S_A_CHK: begin
						if (bytes_q == '0 || nunits > NUNITS_W'(heap)) begin
							status_q <= ST_BAD_SIZE;
							state_q  <= S_DONE;
						end else begin
							rnode_q <= rover_q;
							ret_q   <= S_A_ROVER;
							state_q <= S_RD;
						end
					end
					S_A_ROVER: begin
						prev_q      <= rover_q;
						prev_size_q <= nd.size;
						p_q         <= nd_next;
						rnode_q     <= nd_next;
						steps_q     <= '0;
						ret_q       <= S_A_P;
						state_q     <= S_RD;
					end
					S_A_P: begin
						if (steps_over) begin
							status_q <= ST_NO_FIT;
							state_q  <= S_DONE;
						end else if (NUNITS_W'(nd.size) >= nunits) begin
							rover_q <= prev_q;
							alloc_q <= alloc_sat;
							if (alloc_sat > peak_q) begin
								peak_q <= alloc_sat;
							end
							if (NUNITS_W'(nd.size) == nunits) begin
								// exact fit: unlink p from the list
								if (prev_q == '0) begin
									sentinel_q <= nd.next;
								end else if (node_ok(prev_q, heap)) begin
									we_q    <= 1'b1;
									waddr_q <= ADDR_W'(prev_q - node_t'(1));
									wdata_q <= '{next: nd.next, size: prev_size_q};
								end
								blk_q    <= INDEX_W'(p_q);
								status_q <= ST_OK;
								state_q  <= S_DONE;
							end else begin
								// shrink p and carve the tail end off it
								we_q    <= 1'b1;
								waddr_q <= ADDR_W'(p_q - node_t'(1));
								wdata_q <= '{next: nd.next, size: tail_size};
								rnode_q <= p2;
								p_q     <= p2;
								ret_q   <= S_A_TAIL;
								state_q <= S_RD;
							end
						end else if (p_q == rover_q) begin
							status_q <= ST_NO_FIT;
							state_q  <= S_DONE;
						end else begin
							prev_q      <= p_q;
							prev_size_q <= nd.size;
							p_q         <= nd_next;
							rnode_q     <= nd_next;
							steps_q     <= steps_q + STEP_W'(1);
							ret_q       <= S_A_P;
							state_q     <= S_RD;
						end
					end
					S_A_TAIL: begin
						if (node_ok(p_q, heap)) begin
							we_q    <= 1'b1;
							waddr_q <= ADDR_W'(p_q - node_t'(1));
							wdata_q <= '{next: nd.next, size: SIZE_W'(nunits)};
						end
						blk_q    <= INDEX_W'(p_q);
						status_q <= ST_OK;
						state_q  <= S_DONE;
					end
					S_F_CHK: begin
						if (bp_q == '0) begin
							status_q <= ST_NULL_FREE;
							state_q  <= S_DONE;
						end else if (!node_ok(bp_q, heap)) begin
							status_q <= ST_BAD_FREE;
							state_q  <= S_DONE;
						end else begin
							rnode_q <= bp_q;
							ret_q   <= S_F_BP;
							state_q <= S_RD;
						end
					end
					S_F_BP: begin
						if (nd.size == '0 || ((NODE_W+1)'(bp_q - node_t'(1))
							+ (NODE_W+1)'(nd.size)) > (NODE_W+1)'(heap)) begin
							status_q <= ST_BAD_FREE;
							state_q  <= S_DONE;
						end else begin
							bp_size_q <= nd.size;
							p_q       <= rover_q;
							rnode_q   <= rover_q;
							steps_q   <= '0;
							ret_q     <= S_F_WALK;
							state_q   <= S_RD;
						end
					end
					S_F_WALK: begin
						if (steps_over) begin
							status_q <= ST_BAD_FREE;
							state_q  <= S_DONE;
						end else if ((bp_q > p_q && bp_q < nd_next) || (p_q != bp_q
							&& p_q >= nd_next && (bp_q > p_q || bp_q < nd_next))) begin
							// insertion point found, p stays put for the merge
							p_size_q <= nd.size;
							alloc_q  <= ((CNT_W+1)'(alloc_q) > (CNT_W+1)'(bp_size_q))
								? alloc_q - CNT_W'(bp_size_q) : '0;
							if ((NODE_W+1)'(bp_q) + (NODE_W+1)'(bp_size_q)
								== (NODE_W+1)'(nd_next)) begin
								rnode_q <= nd_next;
								ret_q   <= S_F_UP;
								state_q <= S_RD;
							end else begin
								bp_next_q <= nd.next;
								state_q   <= S_F_WBP;
							end
						end else if (p_q == bp_q) begin
							status_q <= ST_BAD_FREE;
							state_q  <= S_DONE;
						end else begin
							p_q     <= nd_next;
							rnode_q <= nd_next;
							steps_q <= steps_q + STEP_W'(1);
							ret_q   <= S_F_WALK;
							state_q <= S_RD;
						end
					end
					S_F_UP: begin
						bp_size_q <= bp_size_q + nd.size;
						bp_next_q <= nd.next;
						state_q   <= S_F_WBP;
					end
					S_F_WBP: begin
						we_q    <= 1'b1;
						waddr_q <= ADDR_W'(bp_q - node_t'(1));
						wdata_q <= '{next: bp_next_q, size: bp_size_q};
						state_q <= S_F_WP;
					end
					S_F_WP: begin
						if ((NODE_W+1)'(p_q) + (NODE_W+1)'(p_size_q) == (NODE_W+1)'(bp_q)) begin
							// lower neighbour swallows the freed block
							if (p_q == '0) begin
								sentinel_q <= bp_next_q;
							end else if (node_ok(p_q, heap)) begin
								we_q    <= 1'b1;
								waddr_q <= ADDR_W'(p_q - node_t'(1));
								wdata_q <= '{next: bp_next_q, size: p_size_q + bp_size_q};
							end
						end else begin
							if (p_q == '0) begin
								sentinel_q <= NEXT_W'(bp_q);
							end else if (node_ok(p_q, heap)) begin
								we_q    <= 1'b1;
								waddr_q <= ADDR_W'(p_q - node_t'(1));
								wdata_q <= '{next: NEXT_W'(bp_q), size: p_size_q};
							end
						end
						rover_q  <= p_q;
						status_q <= ST_OK;
						state_q  <= S_DONE;
					end
					S_DONE: begin
						if (res_ready) begin
							state_q <= S_IDLE;
						end
					end
					default: begin
						state_q <= S_IDLE;
					end
				endcase
			end
		end
	end

	`NFH_ASSERT(a_alloc_le_peak, clk, arst_n, alloc_q <= peak_q, "allocated count above peak")
	`NFH_ASSERT_IMP(a_fail_blk_zero, clk, arst_n, res_valid && status_q != ST_OK, blk_q == '0, "failed request carries a block index")
	`NFH_ASSERT_IMP(a_write_in_heap, clk, arst_n, we_q && !wclr_q, (CNT_W)'(waddr_q) < heap, "header write outside the heap")

endmodule
